>>> rtl/sps_pkg.sv
// ============================================================================
// sps_pkg: stepper phase sequencer shared definitions
// Types, widths, coil tables and divider constants used by all block files.
// ============================================================================
package sps_pkg;

	localparam int CMD_W   = 2;
	localparam int ANGLE_W = 16;
	localparam int COIL_W  = 4;
	localparam int DELAY_W = 16;
	localparam int SEQ_W   = 17;
	localparam int PHASE_W = 3;

	// Coil sequences for one turn of the output shaft (1 to 4096).
	localparam int STEPS_PER_TURN = 512;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(2500);
	localparam logic [SEQ_W-1:0]   SEQ_MAX     = {SEQ_W{1'b1}};

	// ceil(angle * STEPS_PER_TURN / 360) = floor((num + 359) / 8 / 45).
	// The divide by 45 is a multiply by a rounded-up reciprocal, exact for
	// dividends below 2^28.
	localparam int DEG_PER_TURN = 360;
	localparam int DIV_SHIFT    = 3;
	localparam int NUM_W        = ANGLE_W + $clog2(STEPS_PER_TURN + 1);
	localparam int V_W          = NUM_W + 1;
	localparam int W_W          = V_W - DIV_SHIFT;
	localparam int RECIP_K      = 32;
	localparam int RECIP_M_W    = 27;
	localparam logic [RECIP_M_W-1:0] RECIP_M = RECIP_M_W'(95443718);
	localparam int PROD_W       = W_W + RECIP_M_W;
	localparam int Q_W          = PROD_W - RECIP_K;

	localparam logic [PHASE_W-1:0] FULL_PHASES = PHASE_W'(4);

	localparam logic [COIL_W-1:0] FULL_TABLE [4] = '{4'h9, 4'hA, 4'h6, 4'h5};
	localparam logic [COIL_W-1:0] HALF_TABLE [8] =
		'{4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1};

	localparam logic [COIL_W-1:0] FULL_LAST = 4'h5;
	localparam logic [COIL_W-1:0] HALF_LAST = 4'h1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_FULL  = 2'd1,
		CMD_HALF  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_kind_t;

	// One classified item on its way from the front end to the sequencer.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [SEQ_W-1:0] seq_count;
	} qentry_t;

endpackage

>>> rtl/sps_ifs.sv
// ============================================================================
// sps_ifs: stepper phase sequencer channel interfaces
// Valid/ready channels for command items and coil drive results.
// ============================================================================
interface sps_item_if;
	logic                          valid;
	logic                          ready;
	logic [sps_pkg::CMD_W-1:0]     cmd;
	logic [sps_pkg::ANGLE_W-1:0]   angle_degrees;

	modport source (output valid, output cmd, output angle_degrees, input ready);
	modport sink   (input valid, input cmd, input angle_degrees, output ready);
endinterface

interface sps_result_if;
	logic                         valid;
	logic                         ready;
	logic [sps_pkg::COIL_W-1:0]   coil_pattern;
	logic                         moving;
	logic                         move_done;
	logic                         start_rejected;

	modport source (output valid, output coil_pattern, output moving,
		output move_done, output start_rejected, input ready);
	modport sink   (input valid, input coil_pattern, input moving,
		input move_done, input start_rejected, output ready);
endinterface

>>> rtl/sps_front.sv
// ============================================================================
// sps_front: command front end
// Accepts items, classifies the command and computes the sequence count.
// ============================================================================
module sps_front (
	input  logic              clk,
	input  logic              arst_n,
	sps_item_if.sink          item,
	output logic              push_valid,
	output sps_pkg::qentry_t  push_data,
	input  logic              push_ready
);

	localparam int SAT_W = sps_pkg::Q_W + sps_pkg::SEQ_W;

	logic                         valid_s1;
	sps_pkg::cmd_kind_t           kind_s1;
	logic [sps_pkg::Q_W-1:0]      quot_s1;

	sps_pkg::cmd_kind_t           kind;
	logic [sps_pkg::V_W-1:0]      dividend;
	logic [sps_pkg::W_W-1:0]      scaled;
	logic [sps_pkg::PROD_W-1:0]   prod;
	logic [SAT_W-1:0]             quot_wide;

	assign item.ready = !valid_s1 || push_ready;

	always_comb begin
		unique case (item.cmd)
			sps_pkg::CMD_TICK: kind = sps_pkg::CMD_TICK;
			sps_pkg::CMD_FULL: kind = sps_pkg::CMD_FULL;
			sps_pkg::CMD_HALF: kind = sps_pkg::CMD_HALF;
			default:           kind = sps_pkg::CMD_UNUSED;
		endcase
	end

	always_comb begin
		dividend = sps_pkg::V_W'(item.angle_degrees) * sps_pkg::V_W'(sps_pkg::STEPS_PER_TURN)
			+ sps_pkg::V_W'(sps_pkg::DEG_PER_TURN - 1);
		scaled   = dividend[sps_pkg::V_W-1:sps_pkg::DIV_SHIFT];
		prod     = sps_pkg::PROD_W'(scaled) * sps_pkg::PROD_W'(sps_pkg::RECIP_M);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= kind;
			quot_s1 <= prod[sps_pkg::PROD_W-1:sps_pkg::RECIP_K];
		end
	end

	// Counts beyond the counter width saturate.
	always_comb begin
		quot_wide               = SAT_W'(quot_s1);
		push_valid              = valid_s1;
		push_data.kind          = kind_s1;
		if (quot_wide > SAT_W'(sps_pkg::SEQ_MAX)) begin
			push_data.seq_count = sps_pkg::SEQ_MAX;
		end else begin
			push_data.seq_count = sps_pkg::SEQ_W'(quot_wide);
		end
	end

endmodule

>>> rtl/sps_queue.sv
// ============================================================================
// sps_queue: command queue
// Short register queue between the front end and the phase sequencer.
// ============================================================================
module sps_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  sps_pkg::qentry_t  push_data,
	output logic              push_ready,
	output logic              head_valid,
	output sps_pkg::qentry_t  head_data,
	input  logic              pop
);

	sps_pkg::qentry_t               mem_q [sps_pkg::QDEPTH];
	logic [sps_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [sps_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [sps_pkg::QCNT_W-1:0]     count_q;
	logic                           push;
	logic                           take;

	assign push_ready = count_q != sps_pkg::QCNT_W'(sps_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign take       = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/sps_back.sv
// ============================================================================
// sps_back: phase sequencer
// Runs moves from queued commands and registers one result per command.
// ============================================================================
module sps_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sps_pkg::DELAY_W-1:0]   phase_delay,
	input  logic                          head_valid,
	input  sps_pkg::qentry_t              head_data,
	output logic                          pop,
	sps_result_if.source                  result
);

	logic [sps_pkg::COIL_W-1:0]   coil_q;
	logic                         busy_q;
	logic                         half_q;
	logic [sps_pkg::SEQ_W-1:0]    seq_left_q;
	logic [sps_pkg::PHASE_W-1:0]  phase_q;
	logic [sps_pkg::DELAY_W-1:0]  wait_q;

	logic                         out_valid_q;
	logic [sps_pkg::COIL_W-1:0]   out_coil_q;
	logic                         out_moving_q;
	logic                         out_done_q;
	logic                         out_rej_q;

	logic [sps_pkg::COIL_W-1:0]   coil_n;
	logic                         busy_n;
	logic                         half_n;
	logic [sps_pkg::SEQ_W-1:0]    seq_left_n;
	logic [sps_pkg::PHASE_W-1:0]  phase_n;
	logic [sps_pkg::DELAY_W-1:0]  wait_n;
	logic                         done;
	logic                         rejected;
	logic [sps_pkg::DELAY_W-1:0]  delay_load;
	logic [sps_pkg::PHASE_W-1:0]  phase_inc;
	logic                         wrap;

	assign pop          = head_valid && (!out_valid_q || result.ready);
	assign delay_load   = (phase_delay == '0) ? sps_pkg::DELAY_W'(1) : phase_delay;
	assign phase_inc    = phase_q + 1'b1;
	assign wrap         = half_q ? (phase_inc == '0) : (phase_inc == sps_pkg::FULL_PHASES);

	always_comb begin
		coil_n     = coil_q;
		busy_n     = busy_q;
		half_n     = half_q;
		seq_left_n = seq_left_q;
		phase_n    = phase_q;
		wait_n     = wait_q;
		done       = 1'b0;
		rejected   = 1'b0;
		case (head_data.kind) inside
			sps_pkg::CMD_FULL, sps_pkg::CMD_HALF: begin
				if (busy_q) begin
					rejected = 1'b1;
				end else if (head_data.seq_count != '0) begin
					busy_n     = 1'b1;
					half_n     = head_data.kind == sps_pkg::CMD_HALF;
					seq_left_n = head_data.seq_count;
					phase_n    = '0;
					wait_n     = delay_load;
				end
			end
			sps_pkg::CMD_TICK: begin
				if (busy_q) begin
					if (wait_q > sps_pkg::DELAY_W'(1)) begin
						wait_n = wait_q - 1'b1;
					end else begin
						coil_n  = half_q ? sps_pkg::HALF_TABLE[phase_q]
							: sps_pkg::FULL_TABLE[phase_q[1:0]];
						phase_n = phase_inc;
						if (wrap) begin
							phase_n    = '0;
							seq_left_n = seq_left_q - 1'b1;
							if (seq_left_n == '0) begin
								busy_n = 1'b0;
								done   = 1'b1;
							end
						end
						wait_n = busy_n ? delay_load : '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_q      <= '0;
			busy_q      <= 1'b0;
			half_q      <= 1'b0;
			seq_left_q  <= '0;
			phase_q     <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				coil_q     <= coil_n;
				busy_q     <= busy_n;
				half_q     <= half_n;
				seq_left_q <= seq_left_n;
				phase_q    <= phase_n;
				wait_q     <= wait_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_coil_q   <= coil_n;
			out_moving_q <= busy_n;
			out_done_q   <= done;
			out_rej_q    <= rejected;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.coil_pattern   = out_coil_q;
	assign result.moving         = out_moving_q;
	assign result.move_done      = out_done_q;
	assign result.start_rejected = out_rej_q;

endmodule

>>> rtl/stepper_phase_sequencer.sv
// ============================================================================
// stepper_phase_sequencer: unipolar stepper full/half-step driver
// Sequences four coil outputs from tick and start-move command items.
// ============================================================================
//
// Usage. Items arrive on the item channel (valid/ready); every accepted item
// gives exactly one result transfer on the result channel, in order. cmd 0
// is a tick, 1 starts a full-step move, 2 starts a half-step move, and 3 is
// ignored. A start computes ceil(angle_degrees * 512 / 360) coil sequences;
// each phase waits phase_delay_ticks ticks, and the tick that ends the wait
// drives the next coil pattern. A start during a move is answered with
// start_rejected and leaves the move alone.
// Throughput is one item per cycle until the queue fills. Between the item
// transfer and the earliest result transfer an item passes through the front
// end's stage register after the reciprocal multiplier, the command queue and
// the result register of the sequencer.
// When the receiver stalls, the result register holds, the four-entry queue
// fills, and then item.ready drops; nothing is lost or repeated.
// Reset clears the coils, ends any move and loads a phase delay of 2500.
// phase_delay_ticks is written through cfg_wr_en/cfg_wr_data; the user must do
// this only while idle, as the block itself does not enforce it.
module stepper_phase_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [sps_pkg::DELAY_W-1:0]   cfg_wr_data,
	sps_item_if.sink                      item,
	sps_result_if.source                  result
);

	// Phase delay register, sampled whenever a wait is loaded.
	logic [sps_pkg::DELAY_W-1:0] phase_delay_q;

	logic              push_valid;
	logic              push_ready;
	sps_pkg::qentry_t  push_data;
	logic              head_valid;
	sps_pkg::qentry_t  head_data;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= sps_pkg::DELAY_RESET;
		end else if (cfg_wr_en) begin
			phase_delay_q <= cfg_wr_data;
		end
	end

	// Front end: accepts every item, decodes the command and turns the angle
	// into a sequence count before the item enters the queue.
	sps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// The queue lets the front end keep taking items while the result side
	// is stalled.
	sps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	// Back end: owns the move state and the result register.
	sps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_delay (phase_delay_q),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.result      (result)
	);

	// A finished move has dropped its busy flag on the same result.
	a_done_not_moving: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.move_done |-> !result.moving)
		else $error("move_done reported while still moving");

	// A rejection only happens while a move is running, which goes on.
	a_reject_while_moving: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.start_rejected |-> result.moving && !result.move_done)
		else $error("start_rejected without a running move");

	// The last phase of either table is what stays on the coils.
	a_done_final_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.move_done |->
			(result.coil_pattern == sps_pkg::FULL_LAST ||
			 result.coil_pattern == sps_pkg::HALF_LAST))
		else $error("move ended on a pattern other than a final phase");

endmodule
